// File: src/lla_pkg.sv
// Shared types, constants and codes for the life-like automaton step block.
package lla_pkg;

  // Grid geometry
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned ROW_AW   = $clog2(MAX_ROWS);
  localparam int unsigned COL_AW   = $clog2(MAX_COLS);

  // Register and field widths
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned RULE_W  = 4;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned LFSR_W  = 16;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;
  localparam int unsigned IN_DW   = 16;
  localparam int unsigned OUT_DW  = 8;

  // Galois LFSR feedback and reset values
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [CNT_W-1:0]  ROWS_RESET = 7'd64;
  localparam logic [CNT_W-1:0]  COLS_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ROW_COUNT   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COL_COUNT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SURVIVE_MIN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SURVIVE_MAX = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BIRTH_LOW   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BIRTH_HIGH  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_EDGE_MODE   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_RANDOM_SEED = 3'd7;

  // Request operations
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  // Treatment of cells off the grid
  typedef enum logic [MODE_W-1:0] {
    BORDER_DEAD  = 3'd0,
    BORDER_LIVE  = 3'd1,
    BORDER_NOISE = 3'd2,
    BORDER_WRAP  = 3'd3,
    BORDER_GROW  = 3'd4
  } edge_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_FETCH,
    ST_CELL,
    ST_STORE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_RESP
  } st_e;

  // Incoming request, last field in the lowest bits
  typedef struct packed {
    logic               write_value;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    logic [1:0]         operation;
  } req_t;

  // Result, last field in the lowest bits
  typedef struct packed {
    logic done_res;
    logic read_value;
  } res_t;

  // Rule and edge settings handed to the cell evaluator
  typedef struct packed {
    logic [RULE_W-1:0] survive_min;
    logic [RULE_W-1:0] survive_max;
    logic [RULE_W-1:0] birth_low;
    logic [RULE_W-1:0] birth_high;
    logic [MODE_W-1:0] edge_mode;
  } rule_t;

  // Position of the cell under evaluation
  typedef struct packed {
    logic              top;
    logic              bottom;
    logic [COL_AW-1:0] col;
    logic [COL_AW-1:0] last_col;
  } pos_t;

endpackage

// File: src/lla_row_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lla_row_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one row and read one row into a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/lla_cell_eval.sv
// Neighbour count, edge handling and rule for one cell from three buffered rows.
module lla_cell_eval import lla_pkg::*; (
  input  rule_t               rule_i,
  input  pos_t                pos_i,
  input  logic [MAX_COLS-1:0] above_i,
  input  logic [MAX_COLS-1:0] cur_i,
  input  logic [MAX_COLS-1:0] below_i,
  input  logic [LFSR_W-1:0]   lfsr_i,
  output logic                next_o,
  output logic [LFSR_W-1:0]   lfsr_o
);

  logic              left_off;
  logic              right_off;
  logic [COL_AW-1:0] col_l;
  logic [COL_AW-1:0] col_r;
  logic [7:0]        nb_val;
  logic [7:0]        nb_off;
  logic [3:0]        count;
  logic [LFSR_W-1:0] lfsr;
  logic              nb_bit;
  logic              alive;

  // Neighbour columns, wrapped for the toroid
  assign left_off  = (pos_i.col == '0);
  assign right_off = (pos_i.col == pos_i.last_col);
  assign col_l     = left_off ? pos_i.last_col : pos_i.col - COL_AW'(1);
  assign col_r     = right_off ? '0 : pos_i.col + COL_AW'(1);
  assign alive     = cur_i[pos_i.col];

  // Gather the eight neighbours in visiting order
  always_comb begin
    nb_val = {below_i[col_r], below_i[pos_i.col], below_i[col_l],
              cur_i[col_r], cur_i[col_l],
              above_i[col_r], above_i[pos_i.col], above_i[col_l]};
    nb_off = {pos_i.bottom | right_off, pos_i.bottom, pos_i.bottom | left_off,
              right_off, left_off,
              pos_i.top | right_off, pos_i.top, pos_i.top | left_off};
  end

  // Count neighbours; step the LFSR once per random edge cell
  always_comb begin
    count  = '0;
    lfsr   = lfsr_i;
    nb_bit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!nb_off[i]) begin
        nb_bit = nb_val[i];
      end else begin
        case (rule_i.edge_mode)
          BORDER_LIVE:  nb_bit = 1'b1;
          BORDER_NOISE: begin
            nb_bit = lfsr[0];
            lfsr   = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
          end
          BORDER_WRAP:  nb_bit = nb_val[i];
          default:      nb_bit = 1'b0;
        endcase
      end
      count = count + 4'(nb_bit);
    end
  end

  // Apply survival and birth ranges
  always_comb begin
    if (alive && (count < rule_i.survive_min || count > rule_i.survive_max)) begin
      next_o = 1'b0;
    end else if (!alive && count >= rule_i.birth_low && count <= rule_i.birth_high) begin
      next_o = 1'b1;
    end else begin
      next_o = alive;
    end
  end

  assign lfsr_o = lfsr;

endmodule

// File: src/life_like_automaton_step.sv
// Top level: configuration, request sequencer, row buffers and both grid memories.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------------
//  request  | in  | s_axis_tvalid/s_axis_tready  | operation, row, col, write_value
//  result   | out | m_axis_tvalid/m_axis_tready  | read_value, done_res
//  config   | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// A generation fetches, for each row, the rows above, at and below through the single
// read port, evaluates one cell per cycle and stores the row, then copies the new
// generation back row by row. After reset a clearing pass zeroes the grid one row at a
// time before the first request. One request is worked on at a time; a new one is
// taken while a result waits in the output register, and a stalled result holds the
// sequencer only at its end.
module life_like_automaton_step import lla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,  // operation[1:0], row[7:2], col[13:8],
                                           // write_value[14], zero[15]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,  // read_value[0], done_res[1], zero[7:2]
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned REQ_W = $bits(req_t);
  localparam int unsigned RES_W = $bits(res_t);

  // Configuration
  logic [CNT_W-1:0] row_count_q;
  logic [CNT_W-1:0] col_count_q;
  rule_t            rule_q;

  // Sequencer
  st_e               state_q, state_d;
  logic [ROW_AW-1:0] row_q, row_d;
  logic [COL_AW-1:0] col_q, col_d;
  logic [1:0]        ph_q, ph_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  req_t              req_q, req_d;
  res_t              res_q, res_d;

  // Row buffers
  logic [MAX_COLS-1:0] above_q, above_d;
  logic [MAX_COLS-1:0] cur_q, cur_d;
  logic [MAX_COLS-1:0] below_q, below_d;
  logic [MAX_COLS-1:0] next_row_q, next_row_d;

  // Output register
  logic m_valid_q, m_valid_d;
  res_t m_data_q, m_data_d;
  logic out_load;

  // Memory ports
  logic                cell_we;
  logic [ROW_AW-1:0]   cell_waddr, cell_raddr;
  logic [MAX_COLS-1:0] cell_wdata, cell_rdata;
  logic                next_we;
  logic [ROW_AW-1:0]   next_waddr, next_raddr;
  logic [MAX_COLS-1:0] next_wdata, next_rdata;

  // Derived values
  req_t              s_req;
  logic [CNT_W-1:0]  nr, nc;
  logic [ROW_AW-1:0] nr_last, above_addr, below_addr;
  logic [COL_AW-1:0] nc_last;
  logic              in_area;
  pos_t              pos;
  logic              eval_next;
  logic [LFSR_W-1:0] eval_lfsr;

  assign s_req   = req_t'(s_axis_tdata[REQ_W-1:0]);
  assign nr      = (row_count_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_q;
  assign nc      = (col_count_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count_q;
  assign nr_last = ROW_AW'(nr - CNT_W'(1));
  assign nc_last = COL_AW'(nc - CNT_W'(1));
  assign in_area = (CNT_W'(req_q.row) < nr) && (CNT_W'(req_q.col) < nc);

  // Neighbour rows, wrapped at the grid edges
  assign above_addr = (row_q == '0) ? nr_last : row_q - ROW_AW'(1);
  assign below_addr = (row_q == nr_last) ? '0 : row_q + ROW_AW'(1);

  assign pos = '{top: (row_q == '0), bottom: (row_q == nr_last),
                 col: col_q, last_col: nc_last};

  // Current generation
  lla_row_ram #(.Depth(MAX_ROWS), .Width(MAX_COLS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  // Next generation
  lla_row_ram #(.Depth(MAX_ROWS), .Width(MAX_COLS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  lla_cell_eval u_cell_eval (
    .rule_i  (rule_q),
    .pos_i   (pos),
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below_q),
    .lfsr_i  (lfsr_q),
    .next_o  (eval_next),
    .lfsr_o  (eval_lfsr)
  );

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROWS_RESET;
      col_count_q <= COLS_RESET;
      rule_q      <= '{survive_min: 4'd2, survive_max: 4'd3, birth_low: 4'd3,
                       birth_high: 4'd3, edge_mode: BORDER_DEAD};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_COUNT:   row_count_q        <= cfg_data_i[CNT_W-1:0];
        REG_COL_COUNT:   col_count_q        <= cfg_data_i[CNT_W-1:0];
        REG_SURVIVE_MIN: rule_q.survive_min <= cfg_data_i[RULE_W-1:0];
        REG_SURVIVE_MAX: rule_q.survive_max <= cfg_data_i[RULE_W-1:0];
        REG_BIRTH_LOW:   rule_q.birth_low   <= cfg_data_i[RULE_W-1:0];
        REG_BIRTH_HIGH:  rule_q.birth_high  <= cfg_data_i[RULE_W-1:0];
        REG_EDGE_MODE:   rule_q.edge_mode   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state, memory controls and datapath updates
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    ph_d       = ph_q;
    lfsr_d     = lfsr_q;
    req_d      = req_q;
    res_d      = res_q;
    above_d    = above_q;
    cur_d      = cur_q;
    below_d    = below_q;
    next_row_d = next_row_q;
    out_load   = 1'b0;
    m_data_d   = m_data_q;
    cell_we    = 1'b0;
    cell_waddr = row_q;
    cell_wdata = '0;
    cell_raddr = row_q;
    next_we    = 1'b0;
    next_waddr = row_q;
    next_wdata = next_row_q;
    next_raddr = row_q;
    s_axis_tready = 1'b0;

    case (state_q)
      // Zero the grid one row a cycle
      ST_CLEAR: begin
        cell_we = 1'b1;
        if (row_q == ROW_AW'(MAX_ROWS - 1)) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d = row_q + ROW_AW'(1);
        end
      end

      // Take a request and start its row read
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cell_raddr    = ROW_AW'(s_req.row);
        if (s_axis_tvalid) begin
          req_d = s_req;
          case (s_req.operation)
            OP_WRITE, OP_READ: state_d = ST_RMW;
            OP_STEP: begin
              res_d = '{done_res: 1'b1, read_value: 1'b0};
              row_d = '0;
              ph_d  = '0;
              if (nr == '0 || nc == '0) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: begin
              res_d   = '{done_res: 1'b0, read_value: 1'b0};
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Read or modify one bit of the fetched row
      ST_RMW: begin
        cell_waddr = ROW_AW'(req_q.row);
        cell_wdata = cell_rdata;
        cell_wdata[COL_AW'(req_q.col)] = req_q.write_value;
        if (req_q.operation == OP_WRITE) begin
          cell_we = in_area;
          res_d   = '{done_res: 1'b1, read_value: 1'b0};
        end else begin
          res_d = '{done_res: 1'b1,
                    read_value: in_area & cell_rdata[COL_AW'(req_q.col)]};
        end
        state_d = ST_RESP;
      end

      // Fetch the rows above, at and below the current row
      ST_FETCH: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd0) begin
          cell_raddr = above_addr;
        end else if (ph_q == 2'd1) begin
          cell_raddr = row_q;
          above_d    = cell_rdata;
        end else if (ph_q == 2'd2) begin
          cell_raddr = below_addr;
          cur_d      = cell_rdata;
        end else begin
          below_d    = cell_rdata;
          next_row_d = cur_q;
          col_d      = '0;
          state_d    = ST_CELL;
        end
      end

      // Evaluate one cell a cycle
      ST_CELL: begin
        next_row_d[col_q] = eval_next;
        lfsr_d            = eval_lfsr;
        if (col_q == nc_last) begin
          state_d = ST_STORE;
        end else begin
          col_d = col_q + COL_AW'(1);
        end
      end

      // Store the finished row in the next-generation buffer
      ST_STORE: begin
        next_we = 1'b1;
        ph_d    = '0;
        if (row_q == nr_last) begin
          row_d   = '0;
          state_d = ST_COPY_RD;
        end else begin
          row_d   = row_q + ROW_AW'(1);
          state_d = ST_FETCH;
        end
      end

      // Copy the new generation back row by row: read in ST_COPY_RD, write in ST_COPY_WR
      ST_COPY_RD: begin
        state_d = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        cell_we    = 1'b1;
        cell_wdata = next_rdata;
        if (row_q == nr_last) begin
          state_d = ST_RESP;
        end else begin
          row_d   = row_q + ROW_AW'(1);
          state_d = ST_COPY_RD;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          m_data_d = res_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Seed write loads the LFSR at once
    if (cfg_we_i && cfg_idx_i == REG_RANDOM_SEED) begin
      lfsr_d = cfg_data_i[LFSR_W-1:0];
    end
  end

  assign m_valid_d = (m_valid_q & ~m_axis_tready) | out_load;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      row_q     <= '0;
      col_q     <= '0;
      ph_q      <= '0;
      lfsr_q    <= SEED_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      ph_q      <= ph_d;
      lfsr_q    <= lfsr_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    above_q    <= above_d;
    cur_q      <= cur_d;
    below_q    <= below_d;
    next_row_q <= next_row_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DW - RES_W){1'b0}}, m_data_q};

endmodule

// File: sim/life_like_automaton_step_checker.sv
// Checker for the life-like automaton step block: grid predictor and result comparison.
module life_like_automaton_step_checker import lla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [IN_DW-1:0]  req_data_i,   // operation[1:0], row[7:2], col[13:8],
                                          // write_value[14], zero[15]
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [OUT_DW-1:0] res_data_i,   // read_value[0], done_res[1], zero[7:2]
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                waiting_o
);

  localparam int GRID_ROWS  = MAX_ROWS;
  localparam int GRID_COLS  = MAX_COLS;
  localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;

  // Shadow copy of the configuration and the automaton state
  logic [CNT_W-1:0]  row_count_q;
  logic [CNT_W-1:0]  col_count_q;
  logic [RULE_W-1:0] survive_lo_q;
  logic [RULE_W-1:0] survive_hi_q;
  logic [RULE_W-1:0] birth_lo_q;
  logic [RULE_W-1:0] birth_hi_q;
  logic [MODE_W-1:0] edge_mode_q;
  logic [LFSR_W-1:0] edge_lfsr_q;
  bit                live_cells [CELL_COUNT];
  bit                next_cells [CELL_COUNT];

  // Replies predicted for accepted requests, oldest first
  res_t              pending_replies_q [$];

  function automatic int active_rows();
    return (int'(row_count_q) > GRID_ROWS) ? GRID_ROWS : int'(row_count_q);
  endfunction

  function automatic int active_cols();
    return (int'(col_count_q) > GRID_COLS) ? GRID_COLS : int'(col_count_q);
  endfunction

  // Value of a neighbour that may lie one step off the active area
  function automatic bit neighbour_cell(int y, int x, int nr, int nc);
    bit lsb;
    if (y >= 0 && y < nr && x >= 0 && x < nc) begin
      return live_cells[y * GRID_COLS + x];
    end
    case (edge_mode_q)
      BORDER_LIVE: begin
        return 1'b1;
      end
      BORDER_NOISE: begin
        // take the low bit, then advance the Galois register once
        lsb         = edge_lfsr_q[0];
        edge_lfsr_q = (edge_lfsr_q >> 1) ^ (lsb ? LFSR_TAPS : '0);
        return lsb;
      end
      BORDER_WRAP: begin
        return live_cells[((y + nr) % nr) * GRID_COLS + ((x + nc) % nc)];
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Compute one generation into the spare grid, then copy the active area back
  function automatic void run_generation();
    int nr, nc, y, x, dy, dx, idx, count;
    bit cur, nxt;
    nr = active_rows();
    nc = active_cols();
    if (nr == 0 || nc == 0) begin
      return;
    end
    for (y = 0; y < nr; y++) begin
      for (x = 0; x < nc; x++) begin
        idx   = y * GRID_COLS + x;
        cur   = live_cells[idx];
        count = 0;
        // row-major neighbour order matters for the random edge bits
        for (dy = -1; dy <= 1; dy++) begin
          for (dx = -1; dx <= 1; dx++) begin
            if (dy != 0 || dx != 0) begin
              count += int'(neighbour_cell(y + dy, x + dx, nr, nc));
            end
          end
        end
        if (cur && (count < int'(survive_lo_q) || count > int'(survive_hi_q))) begin
          nxt = 1'b0;
        end else if (!cur && count >= int'(birth_lo_q) && count <= int'(birth_hi_q)) begin
          nxt = 1'b1;
        end else begin
          nxt = cur;
        end
        next_cells[idx] = nxt;
      end
    end
    for (y = 0; y < nr; y++) begin
      for (x = 0; x < nc; x++) begin
        live_cells[y * GRID_COLS + x] = next_cells[y * GRID_COLS + x];
      end
    end
  endfunction

  // Work out the reply to one request and update the shadow grid
  function automatic res_t predict_reply(req_t req);
    res_t reply;
    bit   in_area;
    int   idx;
    in_area          = (int'(req.row) < active_rows()) && (int'(req.col) < active_cols());
    idx              = int'(req.row) * GRID_COLS + int'(req.col);
    reply.read_value = 1'b0;
    reply.done_res   = 1'b1;
    case (req.operation)
      OP_WRITE: begin
        if (in_area) begin
          live_cells[idx] = req.write_value;
        end
      end
      OP_READ: begin
        if (in_area) begin
          reply.read_value = live_cells[idx];
        end
      end
      OP_STEP: begin
        run_generation();
      end
      default: begin
        reply.done_res = 1'b0;
      end
    endcase
    return reply;
  endfunction

  function automatic void note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endfunction

  // Compare a result with the oldest prediction, field by field
  function automatic void check_reply(res_t got);
    res_t want;
    if (pending_replies_q.size() == 0) begin
      note_failure($sformatf("result with nothing expected: read_value %0d done_res %0d",
                             got.read_value, got.done_res));
      return;
    end
    want = pending_replies_q.pop_front();
    if (got.read_value !== want.read_value) begin
      note_failure($sformatf("read_value expected %0d, got %0d",
                             want.read_value, got.read_value));
    end
    if (got.done_res !== want.done_res) begin
      note_failure($sformatf("done_res expected %0d, got %0d",
                             want.done_res, got.done_res));
    end
  endfunction

  function automatic void apply_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      REG_ROW_COUNT:   row_count_q  = data[CNT_W-1:0];
      REG_COL_COUNT:   col_count_q  = data[CNT_W-1:0];
      REG_SURVIVE_MIN: survive_lo_q = data[RULE_W-1:0];
      REG_SURVIVE_MAX: survive_hi_q = data[RULE_W-1:0];
      REG_BIRTH_LOW:   birth_lo_q   = data[RULE_W-1:0];
      REG_BIRTH_HIGH:  birth_hi_q   = data[RULE_W-1:0];
      REG_EDGE_MODE:   edge_mode_q  = data[MODE_W-1:0];
      // the seed loads the edge register at once
      REG_RANDOM_SEED: edge_lfsr_q  = data[LFSR_W-1:0];
      default: ;
    endcase
  endfunction

  // Watch the channels: config first, then results, then new requests
  always @(posedge clk_i or negedge rst_ni) begin
    int i;
    if (!rst_ni) begin
      row_count_q  = ROWS_RESET;
      col_count_q  = COLS_RESET;
      survive_lo_q = 4'd2;
      survive_hi_q = 4'd3;
      birth_lo_q   = 4'd3;
      birth_hi_q   = 4'd3;
      edge_mode_q  = BORDER_DEAD;
      edge_lfsr_q  = SEED_RESET;
      for (i = 0; i < CELL_COUNT; i++) begin
        live_cells[i] = 1'b0;
        next_cells[i] = 1'b0;
      end
      pending_replies_q.delete();
      fail_count_o = 0;
      waiting_o    = 0;
    end else begin
      if (cfg_we_i) begin
        apply_register(cfg_idx_i, cfg_data_i);
      end
      if (res_valid_i && res_ready_i) begin
        check_reply(res_t'(res_data_i[1:0]));
      end
      if (req_valid_i && req_ready_i) begin
        pending_replies_q.push_back(predict_reply(req_t'(req_data_i[14:0])));
      end
      waiting_o = pending_replies_q.size();
    end
  end

endmodule

// File: sim/life_like_automaton_step_tb.sv
// Testbench top for the life-like automaton step block: stimulus, stalls and verdict.
module life_like_automaton_step_tb;
  import lla_pkg::*;

  localparam int         CYCLE_LIMIT   = 800000;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_ITEMS   = 15;
  localparam logic [1:0] OP_UNKNOWN    = 2'd3;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i     = '0;
  logic [CFG_DW-1:0] cfg_data_i    = '0;

  int fail_count;
  int waiting;
  int cycle_count       = 0;
  int requests_sent     = 0;
  int generations_sent  = 0;
  int settings_used     = 0;
  int area_rows         = MAX_ROWS;
  int area_cols         = MAX_COLS;
  bit idling            = 1'b1;

  always #5 clk_i = ~clk_i;

  life_like_automaton_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  life_like_automaton_step_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, waiting);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request, after a random gap while idling, and hold it until taken
  task automatic send_request(input logic [1:0] op, input int row, input int col,
                              input bit value);
    req_t req;
    int   gap;
    req.operation   = op;
    req.row         = FIELD_W'(row);
    req.col         = FIELD_W'(col);
    req.write_value = value;
    gap = idling ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, req};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (op == OP_STEP) begin
      generations_sent++;
    end
  endtask

  // Drop valid and wait until every reply is in and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DW'(data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Load a full set of registers once the block is idle
  task automatic apply_settings(input int rows, input int cols, input int smin, input int smax,
                                input int blo, input int bhi, input int mode, input int seed);
    settle();
    write_reg(REG_ROW_COUNT,   rows);
    write_reg(REG_COL_COUNT,   cols);
    write_reg(REG_SURVIVE_MIN, smin);
    write_reg(REG_SURVIVE_MAX, smax);
    write_reg(REG_BIRTH_LOW,   blo);
    write_reg(REG_BIRTH_HIGH,  bhi);
    write_reg(REG_EDGE_MODE,   mode);
    write_reg(REG_RANDOM_SEED, seed);
    area_rows = (rows > int'(MAX_ROWS)) ? int'(MAX_ROWS) : rows;
    area_cols = (cols > int'(MAX_COLS)) ? int'(MAX_COLS) : cols;
    settings_used++;
  endtask

  // Mostly small grids keep generations short; a few are empty or full size
  function automatic int pick_size();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      return 0;
    end else if (k == 1) begin
      return $urandom_range(64, 127);
    end else if (k <= 3) begin
      return $urandom_range(11, 40);
    end
    return $urandom_range(1, 10);
  endfunction

  function automatic int pick_rule();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
  endfunction

  // Result side: while idling, stall a random number of cycles before each reply
  initial begin
    int stall;
    forever begin
      stall = idling ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Request side: directed cases, then random phases
  initial begin
    int phase, k, choice, row, col, step_budget;
    int rows, cols, smin, smax, blo, bhi, mode, seed, tmp;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty grid, corner cells, a blinker on the top edge
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 63, 63, 1'b0);
    send_request(OP_WRITE, 63, 63, 1'b1);
    send_request(OP_READ, 63, 63, 1'b0);
    send_request(OP_WRITE, 0, 0, 1'b1);
    send_request(OP_WRITE, 0, 1, 1'b1);
    send_request(OP_WRITE, 0, 2, 1'b1);
    send_request(OP_STEP, 0, 0, 1'b0);
    send_request(OP_READ, 1, 1, 1'b0);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_UNKNOWN, 63, 63, 1'b1);

    // zero columns: writes fall outside, a generation does nothing
    apply_settings(3, 0, 2, 3, 3, 3, BORDER_DEAD, SEED_RESET);
    send_request(OP_WRITE, 1, 1, 1'b1);
    send_request(OP_READ, 1, 1, 1'b0);
    send_request(OP_STEP, 0, 0, 1'b0);

    // live border, widest count register, reads beyond the active rows
    apply_settings(2, 127, 0, 8, 8, 8, BORDER_LIVE, 1);
    send_request(OP_STEP, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b0);
    send_request(OP_READ, 2, 0, 1'b0);

    // wrapped blinker on the smallest torus
    apply_settings(3, 3, 2, 3, 3, 3, BORDER_WRAP, SEED_RESET);
    send_request(OP_WRITE, 1, 0, 1'b1);
    send_request(OP_WRITE, 1, 1, 1'b1);
    send_request(OP_WRITE, 1, 2, 1'b1);
    send_request(OP_STEP, 0, 0, 1'b0);
    send_request(OP_READ, 0, 0, 1'b0);

    // random border from an all-ones seed
    apply_settings(4, 5, 1, 5, 1, 3, BORDER_NOISE, 16'hFFFF);
    send_request(OP_STEP, 0, 0, 1'b0);
    send_request(OP_READ, 3, 4, 1'b0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idling = ($urandom_range(0, 3) != 0);
      rows   = pick_size();
      cols   = pick_size();
      smin   = pick_rule();
      smax   = pick_rule();
      blo    = pick_rule();
      bhi    = pick_rule();
      // keep most ranges in order so that patterns live on
      if (smin > smax && $urandom_range(0, 2) != 0) begin
        tmp = smin; smin = smax; smax = tmp;
      end
      if (blo > bhi && $urandom_range(0, 2) != 0) begin
        tmp = blo; blo = bhi; bhi = tmp;
      end
      mode = $urandom_range(0, 9);
      if (mode > 7) begin
        mode = (mode == 8) ? BORDER_NOISE : BORDER_WRAP;
      end
      k = $urandom_range(0, 9);
      seed = (k == 0) ? 0 : (k == 1) ? 16'hFFFF : $urandom_range(1, 65535);
      apply_settings(rows, cols, smin, smax, blo, bhi, mode, seed);

      // large areas make generations slow: allow only one there
      step_budget = (area_rows * area_cols > 400) ? 1 : 6;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        choice = $urandom_range(0, 19);
        if (area_rows > 0 && area_cols > 0 && $urandom_range(0, 6) != 0) begin
          row = $urandom_range(0, area_rows - 1);
          col = $urandom_range(0, area_cols - 1);
        end else begin
          row = $urandom_range(0, 63);
          col = $urandom_range(0, 63);
        end
        if (choice < 8) begin
          send_request(OP_WRITE, row, col, 1'($urandom_range(0, 1)));
        end else if (choice >= 13 && choice < 17 && step_budget > 0) begin
          step_budget--;
          send_request(OP_STEP, row, col, 1'($urandom_range(0, 1)));
        end else if (choice == 19) begin
          send_request(OP_UNKNOWN, row, col, 1'($urandom_range(0, 1)));
        end else begin
          send_request(OP_READ, row, col, 1'($urandom_range(0, 1)));
        end
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("Summary: %0d requests, %0d of them generations, under %0d register settings",
             requests_sent, generations_sent, settings_used + 1);
    $display("Summary: %0d mismatches, %0d replies outstanding", fail_count, waiting);
    if (fail_count == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
